>>> sv/dass_pkg.sv
// ----------------------------------------------------------------------------
// dass_pkg
// Shared types, codes and constants of the dual converter scan sequencer.
// ----------------------------------------------------------------------------
package dass_pkg;

   // number of converter inputs scanned per device
   localparam int CHANNELS_DEF = 4;
   localparam int CHAN_W       = 2;
   localparam int CACHE_DEPTH  = 8;
   localparam int CACHE_AW     = 3;

   // reset values of the control registers
   localparam logic       RST_SCAN_ENABLE = 1'b1;
   localparam logic [7:0] RST_CONVERT_WAIT = 8'd8;
   localparam logic [6:0] RST_DEV_A_ADDR  = 7'h48;
   localparam logic [6:0] RST_DEV_B_ADDR  = 7'h49;
   localparam logic [7:0] RST_CFG_LOW     = 8'h83;

   // fixed bytes of the bus commands
   localparam logic [7:0] CFG_REG_PTR     = 8'h01;
   localparam logic [7:0] CONV_REG_PTR    = 8'h00;

   typedef enum logic [1:0] {
      OP_POLL  = 2'd0,
      OP_DONE  = 2'd1,
      OP_ERROR = 2'd2,
      OP_HOST  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_CONFIG  = 2'd0,
      KIND_POINTER = 2'd1,
      KIND_READ    = 2'd2
   } cmd_kind_type;

   typedef enum logic [2:0] {
      REG_SCAN_ENABLE  = 3'd0,
      REG_CONVERT_WAIT = 3'd1,
      REG_DEV_A_ADDR   = 3'd2,
      REG_DEV_B_ADDR   = 3'd3,
      REG_CFG_LOW      = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic       scan_enable;
      logic [7:0] convert_wait_ms;
      logic [6:0] device_a_address;
      logic [6:0] device_b_address;
      logic [7:0] config_low_byte;
   } csr_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic [15:0] rx_word;
      logic [3:0]  error_code;
      logic [3:0]  host_index;
   } req_item_type;

   typedef struct packed {
      logic        cmd_valid;
      logic [1:0]  cmd_kind;
      logic [6:0]  cmd_address;
      logic [23:0] cmd_bytes;
      logic [15:0] host_data;
      logic        error_flag;
      logic [3:0]  error_last;
   } rsp_item_type;

   // mux field of the converter config word, one code per input
   function automatic logic [7:0] mux_byte(input logic [CHAN_W-1:0] ch);
      logic [7:0] code;
      case (ch)
         2'd0:    code = 8'hC9;
         2'd1:    code = 8'hD9;
         2'd2:    code = 8'hE9;
         default: code = 8'hF9;
      endcase
      return code;
   endfunction

endpackage

>>> sv/dass_core.sv
// ----------------------------------------------------------------------------
// dass_core
// Scan phase machine, result cache and error record; one item per step.
// ----------------------------------------------------------------------------
module dass_core
   import dass_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  csr_type      csr,
   output rsp_item_type result
);

   typedef enum logic [2:0] {
      PH_CONFIG  = 3'd0,
      PH_POINTER = 3'd1,
      PH_WAIT    = 3'd2,
      PH_READ    = 3'd3,
      PH_CACHE   = 3'd4
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic                dev_sel_ff, dev_sel_in;
   logic [CHAN_W-1:0]   channel_ff, channel_in;
   logic                busy_ff, busy_in;
   logic [31:0]         wait_start_ff, wait_start_in;
   logic [15:0]         rx_hold_ff, rx_hold_in;
   logic                err_seen_ff, err_seen_in;
   logic [3:0]          err_code_ff, err_code_in;

   logic [15:0]         cache_ff [CACHE_DEPTH];
   logic                cache_we;
   logic [CACHE_AW-1:0] cache_wa;

   logic [6:0]          dev_addr;
   logic [31:0]         elapsed;

   assign dev_addr = dev_sel_ff ? csr.device_b_address : csr.device_a_address;
   assign elapsed  = item.now_ms - wait_start_ff;

   always_comb begin
      phase_in      = phase_ff;
      dev_sel_in    = dev_sel_ff;
      channel_in    = channel_ff;
      busy_in       = busy_ff;
      wait_start_in = wait_start_ff;
      rx_hold_in    = rx_hold_ff;
      err_seen_in   = err_seen_ff;
      err_code_in   = err_code_ff;
      cache_we      = 1'b0;
      cache_wa      = {1'b0, channel_ff};
      result        = '0;

      if (step) begin
         case (item.opcode)
            OP_POLL: begin
               if (csr.scan_enable && !busy_ff) begin
                  unique case (phase_ff)
                     PH_CONFIG: begin
                        busy_in            = 1'b1;
                        result.cmd_valid   = 1'b1;
                        result.cmd_kind    = KIND_CONFIG;
                        result.cmd_address = dev_addr;
                        result.cmd_bytes   = {CFG_REG_PTR, mux_byte(channel_ff),
                                              csr.config_low_byte};
                        if (dev_sel_ff) begin
                           phase_in = PH_POINTER;
                        end
                        dev_sel_in = !dev_sel_ff;
                     end
                     PH_POINTER: begin
                        busy_in            = 1'b1;
                        result.cmd_valid   = 1'b1;
                        result.cmd_kind    = KIND_POINTER;
                        result.cmd_address = dev_addr;
                        result.cmd_bytes   = {CONV_REG_PTR, 16'h0000};
                        if (dev_sel_ff) begin
                           wait_start_in = item.now_ms;
                           phase_in      = PH_WAIT;
                        end
                        dev_sel_in = !dev_sel_ff;
                     end
                     PH_WAIT: begin
                        if (elapsed > {24'h000000, csr.convert_wait_ms}) begin
                           phase_in = PH_READ;
                        end
                     end
                     PH_READ: begin
                        busy_in            = 1'b1;
                        result.cmd_valid   = 1'b1;
                        result.cmd_kind    = KIND_READ;
                        result.cmd_address = dev_addr;
                        phase_in           = PH_CACHE;
                     end
                     PH_CACHE: begin
                        cache_we = 1'b1;
                        if (dev_sel_ff) begin
                           // second device lands in the upper half of the cache
                           cache_wa = {1'b0, channel_ff} + CACHE_AW'(CHANNELS);
                           if (channel_ff == CHAN_W'(CHANNELS - 1)) begin
                              channel_in = '0;
                           end else begin
                              channel_in = channel_ff + 1'b1;
                           end
                           phase_in = PH_CONFIG;
                        end else begin
                           phase_in = PH_READ;
                        end
                        dev_sel_in = !dev_sel_ff;
                     end
                     default: phase_in = PH_CONFIG;
                  endcase
               end
            end
            OP_DONE: begin
               // only a finished read carries data worth keeping
               if (busy_ff && phase_ff == PH_CACHE) begin
                  rx_hold_in = item.rx_word;
               end
               busy_in = 1'b0;
            end
            OP_ERROR: begin
               busy_in     = 1'b0;
               err_seen_in = 1'b1;
               err_code_in = item.error_code;
            end
            OP_HOST: begin
               if (!item.host_index[3]) begin
                  result.host_data = cache_ff[item.host_index[CACHE_AW-1:0]];
               end
            end
            default: ;
         endcase
      end

      result.error_flag = err_seen_in;
      result.error_last = err_code_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_CONFIG;
         dev_sel_ff    <= 1'b0;
         channel_ff    <= '0;
         busy_ff       <= 1'b0;
         wait_start_ff <= '0;
         rx_hold_ff    <= '0;
         err_seen_ff   <= 1'b0;
         err_code_ff   <= '0;
      end else begin
         phase_ff      <= phase_in;
         dev_sel_ff    <= dev_sel_in;
         channel_ff    <= channel_in;
         busy_ff       <= busy_in;
         wait_start_ff <= wait_start_in;
         rx_hold_ff    <= rx_hold_in;
         err_seen_ff   <= err_seen_in;
         err_code_ff   <= err_code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            cache_ff[i] <= '0;
         end
      end else if (cache_we) begin
         cache_ff[cache_wa] <= rx_hold_ff;
      end
   end

   // a started transfer leaves the sequencer busy
   assert property (@(posedge clock) disable iff (reset)
      step && result.cmd_valid |=> busy_ff)
      else $error("busy not set after command");

   // nothing is issued while a transfer is outstanding
   assert property (@(posedge clock) disable iff (reset)
      step && busy_ff |-> !result.cmd_valid)
      else $error("command issued while busy");

   // error record is sticky
   assert property (@(posedge clock) disable iff (reset)
      err_seen_ff |=> err_seen_ff)
      else $error("error flag dropped");

   assert property (@(posedge clock) disable iff (reset)
      {1'b0, channel_ff} < (CHAN_W + 1)'(CHANNELS))
      else $error("channel out of range");

endmodule

>>> sv/dual_adc_scan_sequencer_top.sv
// ----------------------------------------------------------------------------
// dual_adc_scan_sequencer_top
// Round-robin scan sequencer for two four-input converters on one bus.
// ----------------------------------------------------------------------------
// path: a transferred request is registered, then its result is registered
//   in the output register, which waits while rsp_stall holds a response
// throughput: one item per cycle unless stalled; one-step phase machine
// reset: phase machine, busy and error record cleared, cache zeroed at once,
//   control registers to defaults; no clearing pass, ready right after reset
module dual_adc_scan_sequencer_top
   import dass_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_rx_word,
   input  logic [3:0]  req_error_code,
   input  logic [3:0]  req_host_index,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_cmd_valid,
   output logic [1:0]  rsp_cmd_kind,
   output logic [6:0]  rsp_cmd_address,
   output logic [23:0] rsp_cmd_bytes,
   output logic [15:0] rsp_host_data,
   output logic        rsp_error_flag,
   output logic [3:0]  rsp_error_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   csr_type      csr_ff, csr_in;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type core_result;
   logic         advance;
   logic         req_xfer;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SCAN_ENABLE:  csr_in.scan_enable      = csr_data[0];
            REG_CONVERT_WAIT: csr_in.convert_wait_ms  = csr_data;
            REG_DEV_A_ADDR:   csr_in.device_a_address = csr_data[6:0];
            REG_DEV_B_ADDR:   csr_in.device_b_address = csr_data[6:0];
            REG_CFG_LOW:      csr_in.config_low_byte  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.scan_enable      <= RST_SCAN_ENABLE;
         csr_ff.convert_wait_ms  <= RST_CONVERT_WAIT;
         csr_ff.device_a_address <= RST_DEV_A_ADDR;
         csr_ff.device_b_address <= RST_DEV_B_ADDR;
         csr_ff.config_low_byte  <= RST_CFG_LOW;
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.opcode     <= req_opcode;
         in_item_ff.now_ms     <= req_now_ms;
         in_item_ff.rx_word    <= req_rx_word;
         in_item_ff.error_code <= req_error_code;
         in_item_ff.host_index <= req_host_index;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   dass_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .csr    (csr_ff),
      .result (core_result)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_cmd_valid   = out_item_ff.cmd_valid;
   assign rsp_cmd_kind    = out_item_ff.cmd_kind;
   assign rsp_cmd_address = out_item_ff.cmd_address;
   assign rsp_cmd_bytes   = out_item_ff.cmd_bytes;
   assign rsp_host_data   = out_item_ff.host_data;
   assign rsp_error_flag  = out_item_ff.error_flag;
   assign rsp_error_last  = out_item_ff.error_last;

endmodule

>>> dv/dass_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dass_checker
// Watches the request, response and csr channels of the scan sequencer,
// predicts each response from its own copy of the scan state and compares.
// ----------------------------------------------------------------------------
module dass_checker
   import dass_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_rx_word,
   input  logic [3:0]  req_error_code,
   input  logic [3:0]  req_host_index,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_cmd_valid,
   input  logic [1:0]  rsp_cmd_kind,
   input  logic [6:0]  rsp_cmd_address,
   input  logic [23:0] rsp_cmd_bytes,
   input  logic [15:0] rsp_host_data,
   input  logic        rsp_error_flag,
   input  logic [3:0]  rsp_error_last,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data,

   output int          fail_count,
   output int          pending,
   output int          checked
);

   typedef enum logic [2:0] {
      SCAN_CONFIG  = 3'd0,
      SCAN_POINTER = 3'd1,
      SCAN_WAIT    = 3'd2,
      SCAN_READ    = 3'd3,
      SCAN_CACHE   = 3'd4
   } scan_phase_type;

   csr_type        regs;
   scan_phase_type phase;
   logic           dev_sel;
   logic [1:0]     chan;
   logic           busy;
   logic [31:0]    wait_start;
   logic [15:0]    rx_hold;
   logic [15:0]    word_cache [CACHE_DEPTH];
   logic           err_seen;
   logic [3:0]     err_code;

   rsp_item_type   expected_rsp_q [$];

   task automatic clear_scan_state();
      regs.scan_enable      = RST_SCAN_ENABLE;
      regs.convert_wait_ms  = RST_CONVERT_WAIT;
      regs.device_a_address = RST_DEV_A_ADDR;
      regs.device_b_address = RST_DEV_B_ADDR;
      regs.config_low_byte  = RST_CFG_LOW;
      phase      = SCAN_CONFIG;
      dev_sel    = 1'b0;
      chan       = '0;
      busy       = 1'b0;
      wait_start = '0;
      rx_hold    = '0;
      for (int i = 0; i < CACHE_DEPTH; i++) word_cache[i] = '0;
      err_seen   = 1'b0;
      err_code   = '0;
   endtask

   // advance the scan machine by one request and build its response
   task automatic scan_step(input req_item_type it, output rsp_item_type r);
      logic [6:0] target;
      logic [7:0] mux;
      r = '0;
      target = dev_sel ? regs.device_b_address : regs.device_a_address;
      case (opcode_type'(it.opcode))
         OP_POLL: begin
            if (regs.scan_enable && !busy) begin
               case (phase)
                  SCAN_CONFIG: begin
                     case (chan)
                        2'd0:    mux = 8'hC9;
                        2'd1:    mux = 8'hD9;
                        2'd2:    mux = 8'hE9;
                        default: mux = 8'hF9;
                     endcase
                     busy          = 1'b1;
                     r.cmd_valid   = 1'b1;
                     r.cmd_kind    = KIND_CONFIG;
                     r.cmd_address = target;
                     r.cmd_bytes   = {CFG_REG_PTR, mux, regs.config_low_byte};
                     if (dev_sel) phase = SCAN_POINTER;
                     dev_sel = ~dev_sel;
                  end
                  SCAN_POINTER: begin
                     busy          = 1'b1;
                     r.cmd_valid   = 1'b1;
                     r.cmd_kind    = KIND_POINTER;
                     r.cmd_address = target;
                     r.cmd_bytes   = {CONV_REG_PTR, 16'h0000};
                     if (dev_sel) begin
                        wait_start = it.now_ms;
                        phase      = SCAN_WAIT;
                     end
                     dev_sel = ~dev_sel;
                  end
                  SCAN_WAIT: begin
                     // elapsed time wraps modulo 2^32
                     if ((it.now_ms - wait_start) > {24'd0, regs.convert_wait_ms})
                        phase = SCAN_READ;
                  end
                  SCAN_READ: begin
                     busy          = 1'b1;
                     r.cmd_valid   = 1'b1;
                     r.cmd_kind    = KIND_READ;
                     r.cmd_address = target;
                     phase         = SCAN_CACHE;
                  end
                  SCAN_CACHE: begin
                     if (dev_sel) begin
                        word_cache[{1'b1, chan}] = rx_hold;
                        chan  = (chan == CHAN_W'(CHANNELS_DEF - 1)) ? '0 : chan + 1'b1;
                        phase = SCAN_CONFIG;
                     end else begin
                        word_cache[{1'b0, chan}] = rx_hold;
                        phase = SCAN_READ;
                     end
                     dev_sel = ~dev_sel;
                  end
                  default: phase = SCAN_CONFIG;
               endcase
            end
         end
         OP_DONE: begin
            // read data is only latched while a read is outstanding
            if (busy && phase == SCAN_CACHE) rx_hold = it.rx_word;
            busy = 1'b0;
         end
         OP_ERROR: begin
            busy     = 1'b0;
            err_seen = 1'b1;
            err_code = it.error_code;
         end
         default: begin
            if (it.host_index < 4'd8) r.host_data = word_cache[it.host_index[2:0]];
         end
      endcase
      r.error_flag = err_seen;
      r.error_last = err_code;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("rsp %s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      req_item_type it;
      rsp_item_type want;
      if (reset) begin
         clear_scan_state();
         expected_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_SCAN_ENABLE:  regs.scan_enable      = csr_data[0];
               REG_CONVERT_WAIT: regs.convert_wait_ms  = csr_data;
               REG_DEV_A_ADDR:   regs.device_a_address = csr_data[6:0];
               REG_DEV_B_ADDR:   regs.device_b_address = csr_data[6:0];
               REG_CFG_LOW:      regs.config_low_byte  = csr_data;
               default: ;
            endcase
         end
         // response transfer first: it belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("rsp transfer with no request waiting");
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("cmd_valid",   want.cmd_valid,   rsp_cmd_valid);
               check_field("cmd_kind",    want.cmd_kind,    rsp_cmd_kind);
               check_field("cmd_address", want.cmd_address, rsp_cmd_address);
               check_field("cmd_bytes",   want.cmd_bytes,   rsp_cmd_bytes);
               check_field("host_data",   want.host_data,   rsp_host_data);
               check_field("error_flag",  want.error_flag,  rsp_error_flag);
               check_field("error_last",  want.error_last,  rsp_error_last);
               checked++;
            end
         end
         if (req_valid && !req_stall) begin
            it.opcode     = req_opcode;
            it.now_ms     = req_now_ms;
            it.rx_word    = req_rx_word;
            it.error_code = req_error_code;
            it.host_index = req_host_index;
            scan_step(it, want);
            expected_rsp_q.push_back(want);
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the dual converter scan sequencer: a directed scan of one
// channel with wrapped timing and stale read data, then random event streams
// under several register settings with idle and stall bursts on both sides.
// ----------------------------------------------------------------------------
module tb;
   import dass_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_POLL;
   logic [31:0] req_now_ms = '0;
   logic [15:0] req_rx_word = '0;
   logic [3:0]  req_error_code = '0;
   logic [3:0]  req_host_index = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_cmd_valid;
   logic [1:0]  rsp_cmd_kind;
   logic [6:0]  rsp_cmd_address;
   logic [23:0] rsp_cmd_bytes;
   logic [15:0] rsp_host_data;
   logic        rsp_error_flag;
   logic [3:0]  rsp_error_last;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = REG_SCAN_ENABLE;
   logic [7:0]  csr_data = '0;

   int          fail_count;
   int          pending;
   int          checked;

   int          n_sent = 0;
   int          n_csr = 0;
   int          n_settings = 1;
   bit          bursts_on = 1'b1;
   bit          last_poll = 1'b0;
   logic [31:0] ms_count;
   int          stall_left = 0;

   always #5 clock = ~clock;

   dual_adc_scan_sequencer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_now_ms      (req_now_ms),
      .req_rx_word     (req_rx_word),
      .req_error_code  (req_error_code),
      .req_host_index  (req_host_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cmd_valid   (rsp_cmd_valid),
      .rsp_cmd_kind    (rsp_cmd_kind),
      .rsp_cmd_address (rsp_cmd_address),
      .rsp_cmd_bytes   (rsp_cmd_bytes),
      .rsp_host_data   (rsp_host_data),
      .rsp_error_flag  (rsp_error_flag),
      .rsp_error_last  (rsp_error_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   dass_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_now_ms      (req_now_ms),
      .req_rx_word     (req_rx_word),
      .req_error_code  (req_error_code),
      .req_host_index  (req_host_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cmd_valid   (rsp_cmd_valid),
      .rsp_cmd_kind    (rsp_cmd_kind),
      .rsp_cmd_address (rsp_cmd_address),
      .rsp_cmd_bytes   (rsp_cmd_bytes),
      .rsp_host_data   (rsp_host_data),
      .rsp_error_flag  (rsp_error_flag),
      .rsp_error_last  (rsp_error_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked         (checked)
   );

   // response side backpressure in bursts
   always @(negedge clock) begin
      if (reset || !bursts_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(1, 12) - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left = $urandom_range(1, 30) - 1;
      end
   end

   task automatic send_req(input logic [1:0] op, input logic [31:0] now,
                           input logic [15:0] rx, input logic [3:0] ec,
                           input logic [3:0] hi);
      int gap;
      @(negedge clock);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_now_ms     <= now;
      req_rx_word    <= rx;
      req_error_code <= ec;
      req_host_index <= hi;
      do @(posedge clock); while (req_stall);
      n_sent++;
   endtask

   // mostly poll followed by its completion, with spurious events mixed in
   task automatic send_random();
      int          r;
      logic [1:0]  op;
      logic [31:0] now;
      r = $urandom_range(0, 99);
      if (last_poll)
         op = (r < 70) ? OP_DONE : (r < 76) ? OP_ERROR : (r < 90) ? OP_POLL : OP_HOST;
      else
         op = (r < 65) ? OP_POLL : (r < 80) ? OP_HOST : (r < 93) ? OP_DONE : OP_ERROR;
      if (op == OP_POLL) begin
         if ($urandom_range(0, 39) == 0) ms_count = $urandom;
         else ms_count = ms_count + $urandom_range(0, 24);
         now = ms_count;
      end else begin
         now = $urandom;
      end
      last_poll = (op == OP_POLL);
      send_req(op, now, 16'($urandom_range(0, 16'hFFFF)), 4'($urandom_range(0, 15)),
               4'($urandom_range(0, 15)));
   endtask

   // stop sending and wait until every response has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // write all five registers; called at a falling edge with the block idle
   task automatic apply_setting(input int s);
      logic [7:0] v [5];
      case (s)
         1: v = '{8'h01, 8'h00, 8'h00, 8'h7F, 8'hFF};
         2: v = '{8'h01, 8'hFF, 8'hFF, 8'h80, 8'h00};
         3: v = '{8'hFE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
         4: v = '{8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
         default: v = '{{7'($urandom), 1'b1}, 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom)};
      endcase
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_index_type'(i);
         csr_data  <= v[i];
         do @(posedge clock); while (!csr_ready);
         n_csr++;
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   initial begin
      int n_items;
      ms_count = $urandom;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // spurious events while idle, then one full channel scan at default wait
      send_req(OP_DONE,  32'h0000_0000, 16'hFFFF, 4'h0, 4'h0);
      send_req(OP_ERROR, 32'hFFFF_FFFF, 16'h0000, 4'hF, 4'hF);
      send_req(OP_HOST,  32'h0000_0000, 16'h0000, 4'h0, 4'h0);
      send_req(OP_POLL,  32'h0000_0000, 16'h0000, 4'h0, 4'h0);
      send_req(OP_POLL,  32'h0000_0000, 16'h0000, 4'h0, 4'h0);  // busy, no transfer
      send_req(OP_DONE,  32'h0000_0000, 16'h1234, 4'h0, 4'h0);
      send_req(OP_POLL,  32'h0000_0000, 16'h0000, 4'h0, 4'h0);
      send_req(OP_DONE,  32'h0000_0000, 16'h0000, 4'h0, 4'h0);
      send_req(OP_POLL,  32'h0000_0000, 16'h0000, 4'h0, 4'h0);
      send_req(OP_DONE,  32'h0000_0000, 16'h0000, 4'h0, 4'h0);
      // wait starts just below the counter wrap
      send_req(OP_POLL,  32'hFFFF_FFF8, 16'h0000, 4'h0, 4'h0);
      send_req(OP_DONE,  32'h0000_0000, 16'h0000, 4'h0, 4'h0);
      send_req(OP_POLL,  32'hFFFF_FFFF, 16'h0000, 4'h0, 4'h0);
      send_req(OP_POLL,  32'h0000_0000, 16'h0000, 4'h0, 4'h0);  // elapsed equals wait
      send_req(OP_POLL,  32'h0000_0001, 16'h0000, 4'h0, 4'h0);
      send_req(OP_POLL,  32'h0000_0001, 16'h0000, 4'h0, 4'h0);
      send_req(OP_DONE,  32'h0000_0000, 16'hFFFF, 4'h0, 4'h0);
      send_req(OP_POLL,  32'h0000_0001, 16'h0000, 4'h0, 4'h0);
      send_req(OP_POLL,  32'h0000_0001, 16'h0000, 4'h0, 4'h0);
      // error on the second read leaves the old data to be cached
      send_req(OP_ERROR, 32'h0000_0000, 16'h5A5A, 4'h0, 4'h0);
      send_req(OP_POLL,  32'h0000_0001, 16'h0000, 4'h0, 4'h0);
      send_req(OP_HOST,  32'h0000_0000, 16'h0000, 4'h0, 4'h0);
      send_req(OP_HOST,  32'h0000_0000, 16'h0000, 4'h0, 4'h4);
      send_req(OP_HOST,  32'h0000_0000, 16'h0000, 4'h0, 4'h8);
      send_req(OP_HOST,  32'h0000_0000, 16'h0000, 4'h0, 4'hF);

      for (int s = 0; s < 6; s++) begin
         if (s > 0) begin
            drain();
            apply_setting(s);
         end
         n_items = (s == 3) ? 150 : 250;
         for (int k = 0; k < n_items; k++) begin
            if (s == 5 && k == 100) bursts_on = 1'b0;
            send_random();
         end
      end

      drain();
      repeat (8) @(negedge clock);
      $display("tb: %0d requests sent, %0d responses checked, %0d csr writes, %0d settings",
               n_sent, checked, n_csr, n_settings);
      $display("tb: scans ran under idle and stall bursts, then back to back");
      if (fail_count == 0 && pending == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
